// File: sv/ecd_pkg.sv
package ecd_pkg;

  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_CYC = 1461;
  localparam int unsigned BASE_YEAR    = 1970;

  // 86400 = 128 * 675: split off the low 7 bits, then divide by 675
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_BLOCK = SEC_PER_DAY >> DAY_SHIFT;

  // floor reciprocals; the estimate is at most one low and gets one fix-up step
  localparam logic [22:0] DAY_RECIP  = 23'((64'd1 << 32) / DAY_BLOCK);
  localparam logic [21:0] CYC_RECIP  = 22'((64'd1 << 32) / DAYS_PER_CYC);
  localparam logic [20:0] HOUR_RECIP = 21'((64'd1 << 32) / SEC_PER_HOUR);
  localparam logic [10:0] MIN_RECIP  = 11'((32'd1 << 16) / SEC_PER_MIN);

  // year lengths inside a four-year cycle: 365, 365, 366, 365
  localparam logic [10:0] YEAR1_START = 11'd365;
  localparam logic [10:0] YEAR2_START = 11'd730;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // first day of each month in a common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
  } ecd_split_t;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ecd_date_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } ecd_md_t;

  function automatic ecd_md_t month_day(input logic [8:0] doy, input logic leap);
    ecd_md_t    res;
    logic [3:0] m;
    logic [8:0] start;
    logic [8:0] sel;
    m   = 4'd0;
    sel = 9'd0;
    for (int i = 1; i < 12; i++) begin
      start = MONTH_START[i] + ((leap && i >= 2) ? 9'd1 : 9'd0);
      if (doy >= start) begin
        m   = 4'(i);
        sel = start;
      end
    end
    res.month = m + 4'd1;
    res.day   = 5'(doy - sel) + 5'd1;
    return res;
  endfunction

endpackage

// File: sv/ecd_in_if.sv
interface ecd_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

// File: sv/ecd_out_if.sv
interface ecd_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface

// File: sv/epoch_seconds_to_civil_date_core.sv
// Channel   Dir  Handshake          Payload
// in_chan   in   valid/ready        epoch_seconds[30:0]
// out_chan  out  valid/ready        year, month, day, hour, minute, second
// cfg       in   cfg_we             cfg_wdata[4:0] (zone hours, signed)
//
// One item per cycle unless out_chan stalls, through ten register stages
// (four for the day/second split, six for the calendar and clock fields).
// Each stage holds its own valid bit and advances when empty or when the
// next stage advances, so bubbles collapse and a stall drops nothing.
// rst_n is synchronous: it empties the pipeline and sets the zone to zero.
module epoch_seconds_to_civil_date_core (
  input  logic              clk,
  input  logic              rst_n,
  ecd_in_if.sink            in_chan,
  ecd_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic signed [4:0] cfg_wdata
);

  logic signed [4:0]   zone_r;
  logic                split_valid;
  logic                split_ready;
  ecd_pkg::ecd_split_t split_data;
  ecd_pkg::ecd_date_t  date;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_we) begin
      zone_r <= cfg_wdata;
    end
  end

  ecd_day_split u_split (
    .clk           (clk),
    .rst_n         (rst_n),
    .zone_hours    (zone_r),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .epoch_seconds (in_chan.epoch_seconds),
    .out_valid     (split_valid),
    .out_ready     (split_ready),
    .out_data      (split_data)
  );

  ecd_civil u_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (date)
  );

  assign out_chan.year   = date.year;
  assign out_chan.month  = date.month;
  assign out_chan.day    = date.day;
  assign out_chan.hour   = date.hour;
  assign out_chan.minute = date.minute;
  assign out_chan.second = date.second;

  // an empty output stage means every stage can take a transfer
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with drained output stage");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    split_valid |-> split_data.sod < 17'(ecd_pkg::SEC_PER_DAY))
    else $error("second of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.month >= 4'd1 && out_chan.month <= 4'd12 &&
                        out_chan.day >= 5'd1 && out_chan.day <= 5'd31))
    else $error("month or day out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.hour <= 5'd23 && out_chan.minute <= 6'd59 &&
                        out_chan.second <= 6'd59))
    else $error("time of day out of range");

endmodule

// File: sv/ecd_day_split.sv
module ecd_day_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [4:0]   zone_hours,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [30:0]         epoch_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output ecd_pkg::ecd_split_t out_data
);

  logic va_r, vb_r, vc_r, vd_r;
  logic ra, rb, rc, rd;

  logic [31:0] t_a_r;
  logic [24:0] x_b_r;
  logic [6:0]  lo_b_r;
  logic [15:0] q_b_r;
  logic [15:0] q_c_r;
  logic [10:0] r_c_r;
  logic [6:0]  lo_c_r;
  ecd_pkg::ecd_split_t d_r;

  logic signed [16:0] zone_ext;
  logic signed [16:0] zone_off;
  logic signed [33:0] loc_s;
  logic [31:0]        t_nxt;
  logic [24:0]        x;
  logic [47:0]        prod;
  logic [24:0]        qm;
  logic [10:0]        r_nxt;
  logic               fix;
  logic [10:0]        r_fix;
  ecd_pkg::ecd_split_t d_nxt;

  // a stage moves when it is empty or the one after it moves
  assign rd = !vd_r || out_ready;
  assign rc = !vc_r || rd;
  assign rb = !vb_r || rc;
  assign ra = !va_r || rb;
  assign in_ready = ra;

  always_comb begin
    zone_ext = 17'(zone_hours);
    zone_off = zone_ext * 17'sd3600;
    loc_s    = $signed({3'b000, epoch_seconds}) + 34'(zone_off);
    // clamp local times before the epoch
    t_nxt    = loc_s[33] ? 32'd0 : loc_s[31:0];
  end

  assign x    = t_a_r[31:ecd_pkg::DAY_SHIFT];
  assign prod = 48'(x) * 48'(ecd_pkg::DAY_RECIP);

  assign qm    = 25'(q_b_r) * 25'(ecd_pkg::DAY_BLOCK);
  assign r_nxt = 11'(x_b_r - qm);

  always_comb begin
    fix          = r_c_r >= 11'(ecd_pkg::DAY_BLOCK);
    r_fix        = fix ? r_c_r - 11'(ecd_pkg::DAY_BLOCK) : r_c_r;
    d_nxt.days   = q_c_r + 16'(fix);
    d_nxt.sod    = {r_fix[9:0], lo_c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ra) va_r <= in_valid;
      if (rb) vb_r <= va_r;
      if (rc) vc_r <= vb_r;
      if (rd) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) t_a_r <= t_nxt;
    if (rb && va_r) begin
      x_b_r  <= x;
      lo_b_r <= t_a_r[ecd_pkg::DAY_SHIFT-1:0];
      q_b_r  <= prod[47:32];
    end
    if (rc && vb_r) begin
      q_c_r  <= q_b_r;
      r_c_r  <= r_nxt;
      lo_c_r <= lo_b_r;
    end
    if (rd && vc_r) d_r <= d_nxt;
  end

  assign out_valid = vd_r;
  assign out_data  = d_r;

endmodule

// File: sv/ecd_civil.sv
module ecd_civil (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecd_pkg::ecd_split_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ecd_pkg::ecd_date_t  out_data
);

  logic [5:0] v_r;
  logic [5:0] rdy;

  // stage E: reciprocal estimates
  logic [15:0] days_e_r;
  logic [16:0] sod_e_r;
  logic [5:0]  cyc_e_r;
  logic [4:0]  hr_e_r;
  // stage F: raw remainders
  logic [5:0]  cyc_f_r;
  logic [11:0] rem_f_r;
  logic [4:0]  hr_f_r;
  logic [12:0] hrem_f_r;
  // stage G: corrected quotients and remainders
  logic [5:0]  cyc_g_r;
  logic [10:0] rem_g_r;
  logic [4:0]  hr_g_r;
  logic [11:0] hrem_g_r;
  // stage H: year in cycle, minute estimate
  logic [5:0]  cyc_h_r;
  logic [1:0]  yoff_h_r;
  logic        leap_h_r;
  logic [8:0]  doy_h_r;
  logic [4:0]  hr_h_r;
  logic [11:0] hrem_h_r;
  logic [5:0]  min_h_r;
  // stage I: calendar fields, raw seconds
  logic [10:0] year_i_r;
  ecd_pkg::ecd_md_t md_i_r;
  logic [4:0]  hr_i_r;
  logic [5:0]  min_i_r;
  logic [6:0]  sec_i_r;
  // stage J: output
  ecd_pkg::ecd_date_t out_r;

  logic [37:0] cyc_prod;
  logic [37:0] hr_prod;
  logic [15:0] cyc_mul;
  logic [16:0] hr_mul;
  logic        cyc_fix, hr_fix;
  logic [1:0]  yoff_nxt;
  logic        leap_nxt;
  logic [10:0] doy_nxt;
  logic [22:0] min_prod;
  logic [11:0] min_mul;
  logic        min_fix;
  ecd_pkg::ecd_date_t out_nxt;

  assign rdy[5] = !v_r[5] || out_ready;
  generate
    for (genvar g = 0; g < 5; g++) begin : g_rdy
      assign rdy[g] = !v_r[g] || rdy[g+1];
    end
  endgenerate
  assign in_ready = rdy[0];

  assign cyc_prod = 38'(in_data.days) * 38'(ecd_pkg::CYC_RECIP);
  assign hr_prod  = 38'(in_data.sod) * 38'(ecd_pkg::HOUR_RECIP);

  assign cyc_mul = 16'(cyc_e_r) * 16'(ecd_pkg::DAYS_PER_CYC);
  assign hr_mul  = 17'(hr_e_r) * 17'(ecd_pkg::SEC_PER_HOUR);

  assign cyc_fix = rem_f_r >= 12'(ecd_pkg::DAYS_PER_CYC);
  assign hr_fix  = hrem_f_r >= 13'(ecd_pkg::SEC_PER_HOUR);

  always_comb begin
    leap_nxt = 1'b0;
    if (rem_g_r < ecd_pkg::YEAR1_START) begin
      yoff_nxt = 2'd0;
      doy_nxt  = rem_g_r;
    end else if (rem_g_r < ecd_pkg::YEAR2_START) begin
      yoff_nxt = 2'd1;
      doy_nxt  = rem_g_r - ecd_pkg::YEAR1_START;
    end else if (rem_g_r < ecd_pkg::YEAR3_START) begin
      yoff_nxt = 2'd2;
      doy_nxt  = rem_g_r - ecd_pkg::YEAR2_START;
      leap_nxt = 1'b1;
    end else begin
      yoff_nxt = 2'd3;
      doy_nxt  = rem_g_r - ecd_pkg::YEAR3_START;
    end
  end

  assign min_prod = 23'(hrem_g_r) * 23'(ecd_pkg::MIN_RECIP);
  assign min_mul  = 12'(min_h_r) * 12'(ecd_pkg::SEC_PER_MIN);
  assign min_fix  = sec_i_r >= 7'(ecd_pkg::SEC_PER_MIN);

  always_comb begin
    out_nxt.year   = year_i_r;
    out_nxt.month  = md_i_r.month;
    out_nxt.day    = md_i_r.day;
    out_nxt.hour   = hr_i_r;
    out_nxt.minute = min_i_r + 6'(min_fix);
    out_nxt.second = 6'(min_fix ? sec_i_r - 7'(ecd_pkg::SEC_PER_MIN) : sec_i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      days_e_r <= in_data.days;
      sod_e_r  <= in_data.sod;
      cyc_e_r  <= cyc_prod[37:32];
      hr_e_r   <= hr_prod[36:32];
    end
    if (rdy[1] && v_r[0]) begin
      cyc_f_r  <= cyc_e_r;
      rem_f_r  <= 12'(days_e_r - cyc_mul);
      hr_f_r   <= hr_e_r;
      hrem_f_r <= 13'(sod_e_r - hr_mul);
    end
    if (rdy[2] && v_r[1]) begin
      cyc_g_r  <= cyc_f_r + 6'(cyc_fix);
      rem_g_r  <= 11'(cyc_fix ? rem_f_r - 12'(ecd_pkg::DAYS_PER_CYC) : rem_f_r);
      hr_g_r   <= hr_f_r + 5'(hr_fix);
      hrem_g_r <= 12'(hr_fix ? hrem_f_r - 13'(ecd_pkg::SEC_PER_HOUR) : hrem_f_r);
    end
    if (rdy[3] && v_r[2]) begin
      cyc_h_r  <= cyc_g_r;
      yoff_h_r <= yoff_nxt;
      leap_h_r <= leap_nxt;
      doy_h_r  <= doy_nxt[8:0];
      hr_h_r   <= hr_g_r;
      hrem_h_r <= hrem_g_r;
      min_h_r  <= min_prod[21:16];
    end
    if (rdy[4] && v_r[3]) begin
      year_i_r <= 11'(ecd_pkg::BASE_YEAR) + {3'b000, cyc_h_r, 2'b00} + 11'(yoff_h_r);
      md_i_r   <= ecd_pkg::month_day(doy_h_r, leap_h_r);
      hr_i_r   <= hr_h_r;
      min_i_r  <= min_h_r;
      sec_i_r  <= 7'(hrem_h_r - min_mul);
    end
    if (rdy[5] && v_r[4]) out_r <= out_nxt;
  end

  assign out_valid = v_r[5];
  assign out_data  = out_r;

endmodule
